@@ hw/rtl/inode_bitmap_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// inode_bitmap_allocator_defines.svh
// Assertion macros for the inode bitmap allocator.
// ----------------------------------------------------------------------------
`ifndef INODE_BITMAP_ALLOCATOR_DEFINES_SVH
`define INODE_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define IBMA_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define IBMA_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define IBMA_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons, msg)
`define IBMA_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons, msg)

`endif

`endif

@@ hw/rtl/ibma_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibma_pkg
// Shared constants, codes and controller/datapath types of the allocator.
// ----------------------------------------------------------------------------
package ibma_pkg;

	localparam int GROUPS          = 8;
	localparam int WORDS_PER_GROUP = 16;
	localparam int WORD_BITS       = 32;
	localparam int TOTAL_WORDS     = GROUPS * WORDS_PER_GROUP;

	localparam int ACT_W  = 2;
	localparam int SLOT_W = 13;
	localparam int SPG_W  = 10;
	localparam int GF_W   = 10;
	localparam int DIR_W  = 10;

	localparam int BIT_W  = $clog2(WORD_BITS);
	localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
	localparam int GCNT_W = $clog2(GROUPS + 1);
	localparam int WIDX_W = (WORDS_PER_GROUP > 1) ? $clog2(WORDS_PER_GROUP) : 1;
	localparam int WCNT_W = $clog2(WORDS_PER_GROUP + 1);
	localparam int ADDR_W = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
	localparam int LOC_W  = WIDX_W + BIT_W;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SLOT_W;

	localparam logic [SPG_W-1:0]  SPG_MIN   = SPG_W'(WORD_BITS);
	localparam logic [SPG_W-1:0]  SPG_MAX   = SPG_W'(WORDS_PER_GROUP * WORD_BITS);
	localparam logic [SPG_W-1:0]  SPG_RESET = SPG_W'(512);
	localparam logic [SLOT_W-1:0] CNT_RESET = SLOT_W'(4096);
	localparam logic [DIR_W-1:0]  DIRS_MAX  = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOTS_PER_GROUP = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT      = CFG_IDX_W'(1);

	typedef enum logic [ACT_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_FREE  = 2'd1,
		ACT_INIT  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_A_GRP,
		ST_A_SCAN,
		ST_F_DIV,
		ST_F_WR,
		ST_I_SWEEP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic start;
		logic grp_next;
		logic div_step;
		logic sweep_step;
		logic total_load;
		logic scan_issue;
		logic alloc_commit;
		logic free_read;
		logic free_commit;
		logic out_load;
		logic out_ok;
	} cmd_t;

	typedef struct packed {
		logic total_zero;
		logic grp_end;
		logic gfree_zero;
		logic word_end;
		logic pend;
		logic word_full;
		logic free_bad;
		logic rem_ge_spg;
		logic sweep_last;
	} sts_t;

endpackage

@@ hw/rtl/ibma_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibma_if
// Request, response and configuration channels of the allocator.
// ----------------------------------------------------------------------------
interface ibma_req_if;
	logic                         valid;
	logic                         ready;
	logic [ibma_pkg::ACT_W-1:0]   action;
	logic [ibma_pkg::SLOT_W-1:0]  slot_number;
	logic                         is_directory;

	modport source (output valid, action, slot_number, is_directory, input ready);
	modport sink   (input valid, action, slot_number, is_directory, output ready);
endinterface

interface ibma_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ibma_pkg::SLOT_W-1:0]  result_slot;
	logic                         ok;
	logic [ibma_pkg::SLOT_W-1:0]  free_total;

	modport source (output valid, result_slot, ok, free_total, input ready);
	modport sink   (input valid, result_slot, ok, free_total, output ready);
endinterface

interface ibma_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [ibma_pkg::CFG_IDX_W-1:0]   index;
	logic [ibma_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/ibma_ctrl.sv @@
`timescale 1ns / 1ps
`include "inode_bitmap_allocator_defines.svh"
// ----------------------------------------------------------------------------
// ibma_ctrl
// Sequencer: decodes the action, steps the scan, division and init sweep,
// and hands the result to the response register.
// ----------------------------------------------------------------------------
module ibma_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic [ibma_pkg::ACT_W-1:0]  req_action,
	output logic                        req_ready,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  ibma_pkg::sts_t              sts,
	output ibma_pkg::cmd_t              cmd
);

	ibma_pkg::state_t state_q, state_d;
	logic             ok_q, ok_d;
	logic             out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ibma_pkg::ST_IDLE;
			ok_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ok_q        <= ok_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ok_d        = ok_q;
		out_valid_d = out_valid_q & ~rsp_ready;
		cmd         = '0;
		req_ready   = 1'b0;
		unique case (state_q)
			ibma_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.start = 1'b1;
					unique case (ibma_pkg::action_t'(req_action))
						ibma_pkg::ACT_ALLOC: begin
							if (sts.total_zero) begin
								ok_d    = 1'b0;
								state_d = ibma_pkg::ST_FIN;
							end else begin
								state_d = ibma_pkg::ST_A_GRP;
							end
						end
						ibma_pkg::ACT_FREE: state_d = ibma_pkg::ST_F_DIV;
						ibma_pkg::ACT_INIT: state_d = ibma_pkg::ST_I_SWEEP;
						default: begin
							ok_d    = 1'b0;
							state_d = ibma_pkg::ST_FIN;
						end
					endcase
				end
			end
			ibma_pkg::ST_A_GRP: begin
				if (sts.grp_end) begin
					ok_d    = 1'b0;
					state_d = ibma_pkg::ST_FIN;
				end else if (sts.gfree_zero) begin
					cmd.grp_next = 1'b1;
				end else begin
					state_d = ibma_pkg::ST_A_SCAN;
				end
			end
			ibma_pkg::ST_A_SCAN: begin
				if (sts.pend && !sts.word_full) begin
					cmd.alloc_commit = 1'b1;
					ok_d             = 1'b1;
					state_d          = ibma_pkg::ST_FIN;
				end else if (!sts.word_end) begin
					cmd.scan_issue = 1'b1;
				end else begin
					cmd.grp_next = 1'b1;
					state_d      = ibma_pkg::ST_A_GRP;
				end
			end
			ibma_pkg::ST_F_DIV: begin
				if (sts.free_bad) begin
					ok_d    = 1'b0;
					state_d = ibma_pkg::ST_FIN;
				end else if (sts.rem_ge_spg) begin
					cmd.div_step = 1'b1;
				end else begin
					cmd.free_read = 1'b1;
					state_d       = ibma_pkg::ST_F_WR;
				end
			end
			ibma_pkg::ST_F_WR: begin
				cmd.free_commit = 1'b1;
				ok_d            = 1'b1;
				state_d         = ibma_pkg::ST_FIN;
			end
			ibma_pkg::ST_I_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					cmd.total_load = 1'b1;
					ok_d           = 1'b1;
					state_d        = ibma_pkg::ST_FIN;
				end
			end
			ibma_pkg::ST_FIN: begin
				cmd.out_ok = ok_q;
				if (!out_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ibma_pkg::ST_IDLE;
				end
			end
			default: state_d = ibma_pkg::ST_IDLE;
		endcase
	end

	assign rsp_valid = out_valid_q;

	`IBMA_ASSERT_IMP(a_load_free, clk, arst_n, cmd.out_load, (!out_valid_q || rsp_ready), "response overwritten while pending")
	`IBMA_ASSERT_NXT(a_one_item, clk, arst_n, (req_valid && req_ready), !req_ready, "request taken while busy")
	`IBMA_ASSERT_NXT(a_alloc_fin, clk, arst_n, cmd.alloc_commit, (state_q == ibma_pkg::ST_FIN && ok_q), "allocate did not finish with success")

endmodule

@@ hw/rtl/ibma_dpath.sv @@
`timescale 1ns / 1ps
`include "inode_bitmap_allocator_defines.svh"
// ----------------------------------------------------------------------------
// ibma_dpath
// Datapath: configuration registers, usage bitmap memory, group and total
// counters, group/word counters, division remainder and result registers.
// ----------------------------------------------------------------------------
module ibma_dpath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [ibma_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ibma_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [ibma_pkg::SLOT_W-1:0]      req_slot_number,
	input  logic                             req_is_directory,
	input  ibma_pkg::cmd_t                   cmd,
	output ibma_pkg::sts_t                   sts,
	output logic [ibma_pkg::SLOT_W-1:0]      result_slot,
	output logic                             ok,
	output logic [ibma_pkg::SLOT_W-1:0]      free_total
);

	localparam int WB     = ibma_pkg::WORD_BITS;
	localparam int SLOT_W = ibma_pkg::SLOT_W;
	localparam int SPG_W  = ibma_pkg::SPG_W;
	localparam int GF_W   = ibma_pkg::GF_W;
	localparam int DIR_W  = ibma_pkg::DIR_W;
	localparam int BIT_W  = ibma_pkg::BIT_W;
	localparam int GRP_W  = ibma_pkg::GRP_W;
	localparam int GCNT_W = ibma_pkg::GCNT_W;
	localparam int WIDX_W = ibma_pkg::WIDX_W;
	localparam int WCNT_W = ibma_pkg::WCNT_W;
	localparam int ADDR_W = ibma_pkg::ADDR_W;
	localparam int LOC_W  = ibma_pkg::LOC_W;

	function automatic logic [BIT_W-1:0] lowest_zero(input logic [WB-1:0] w);
		logic [BIT_W-1:0] pos;
		pos = '0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (!w[i]) pos = BIT_W'(i);
		end
		return pos;
	endfunction

	// configuration
	logic [SPG_W-1:0]  spg_cfg_q;
	logic [SLOT_W-1:0] cnt_cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spg_cfg_q <= ibma_pkg::SPG_RESET;
			cnt_cfg_q <= ibma_pkg::CNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ibma_pkg::CFG_SLOTS_PER_GROUP: spg_cfg_q <= cfg_data[SPG_W-1:0];
				ibma_pkg::CFG_SLOT_COUNT:      cnt_cfg_q <= cfg_data[SLOT_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SPG_W-1:0]  spg_m, spg_e;
	logic [SLOT_W-1:0] cap_all, cnt_e;

	always_comb begin
		spg_m = {spg_cfg_q[SPG_W-1:BIT_W], BIT_W'(0)};
		if (spg_m < ibma_pkg::SPG_MIN) spg_e = ibma_pkg::SPG_MIN;
		else if (spg_m > ibma_pkg::SPG_MAX) spg_e = ibma_pkg::SPG_MAX;
		else spg_e = spg_m;
		cap_all = SLOT_W'(spg_e) * SLOT_W'(ibma_pkg::GROUPS);
		if (cnt_cfg_q == '0) cnt_e = SLOT_W'(1);
		else if (cnt_cfg_q > cap_all) cnt_e = cap_all;
		else cnt_e = cnt_cfg_q;
	end

	// transaction context
	logic [SPG_W-1:0]  spg_q;
	logic [SLOT_W-1:0] cnt_q;
	logic [WCNT_W-1:0] wpg_q;
	logic [SLOT_W-1:0] rem_q;
	logic              dir_q;
	logic              bad_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			spg_q <= spg_e;
			cnt_q <= cnt_e;
			wpg_q <= WCNT_W'(spg_e >> BIT_W);
			rem_q <= req_slot_number - SLOT_W'(1);
			dir_q <= req_is_directory;
			bad_q <= (req_slot_number == '0) || (req_slot_number > cnt_e);
		end else if (cmd.div_step) begin
			rem_q <= rem_q - SLOT_W'(spg_q);
		end
	end

	// group and word position
	logic [GCNT_W-1:0] grp_q;
	logic [WCNT_W-1:0] word_q;
	logic [SLOT_W-1:0] base_q;
	logic              sweep_wrap;

	assign sweep_wrap = (word_q == WCNT_W'(ibma_pkg::WORDS_PER_GROUP - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q  <= '0;
			word_q <= '0;
			base_q <= '0;
		end else if (cmd.start) begin
			grp_q  <= '0;
			word_q <= '0;
			base_q <= '0;
		end else if (cmd.grp_next || cmd.div_step || (cmd.sweep_step && sweep_wrap)) begin
			grp_q  <= grp_q + GCNT_W'(1);
			word_q <= '0;
			base_q <= base_q + SLOT_W'(spg_q);
		end else if (cmd.scan_issue || cmd.sweep_step) begin
			word_q <= word_q + WCNT_W'(1);
		end
	end

	logic [GRP_W-1:0]  grp_idx;
	logic              in_grp_c;
	logic [SLOT_W-1:0] diff_c;
	logic [GF_W-1:0]   cap_c;
	logic [LOC_W-1:0]  loc_c;

	assign grp_idx  = grp_q[GRP_W-1:0];
	assign in_grp_c = (base_q < cnt_q);
	assign diff_c   = cnt_q - base_q;
	assign loc_c    = rem_q[LOC_W-1:0];

	always_comb begin
		if (!in_grp_c) cap_c = '0;
		else if (diff_c < SLOT_W'(spg_q)) cap_c = GF_W'(diff_c);
		else cap_c = GF_W'(spg_q);
	end

	// init word: mark slots past the last group's capacity as used
	logic [LOC_W-1:0]  lo_c;
	logic [SLOT_W-1:0] lo_ext, cap_ext;
	logic [WB-1:0]     init_word_c;

	always_comb begin
		lo_c    = {word_q[WIDX_W-1:0], BIT_W'(0)};
		lo_ext  = SLOT_W'(lo_c);
		cap_ext = SLOT_W'(cap_c);
		if (!in_grp_c || lo_ext >= SLOT_W'(spg_q) || cap_ext >= lo_ext + SLOT_W'(WB))
			init_word_c = '0;
		else if (cap_ext <= lo_ext)
			init_word_c = '1;
		else
			init_word_c = {WB{1'b1}} << BIT_W'(cap_ext - lo_ext);
	end

	// bitmap memory with per-word valid bits
	logic [WB-1:0]     mem_q [ibma_pkg::TOTAL_WORDS];
	logic [ibma_pkg::TOTAL_WORDS-1:0] vld_q;
	logic [WB-1:0]     rdata_s1;
	logic              rvld_s1;
	logic              pend_s1;
	logic [WIDX_W-1:0] widx_s1;
	logic [WB-1:0]     rd_word;
	logic [BIT_W-1:0]  lz_c;

	logic [ADDR_W-1:0] grp_addr, scan_addr, free_addr, alloc_addr, rd_addr, wr_addr;
	logic              wr_en;
	logic [WB-1:0]     wr_data;

	assign grp_addr   = ADDR_W'(grp_idx) * ADDR_W'(ibma_pkg::WORDS_PER_GROUP);
	assign scan_addr  = grp_addr + ADDR_W'(word_q[WIDX_W-1:0]);
	assign free_addr  = grp_addr + ADDR_W'(loc_c[LOC_W-1:BIT_W]);
	assign alloc_addr = grp_addr + ADDR_W'(widx_s1);
	assign rd_addr    = cmd.free_read ? free_addr : scan_addr;
	assign rd_word    = rvld_s1 ? rdata_s1 : '0;
	assign lz_c       = lowest_zero(rd_word);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_addr;
		wr_data = init_word_c;
		if (cmd.sweep_step) begin
			wr_en = 1'b1;
		end else if (cmd.alloc_commit) begin
			wr_en   = 1'b1;
			wr_addr = alloc_addr;
			wr_data = rd_word | (WB'(1) << lz_c);
		end else if (cmd.free_commit) begin
			wr_en   = 1'b1;
			wr_addr = free_addr;
			wr_data = rd_word & ~(WB'(1) << loc_c[BIT_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rdata_s1 <= mem_q[rd_addr];
		if (cmd.scan_issue) widx_s1 <= word_q[WIDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
			pend_s1 <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			rvld_s1 <= vld_q[rd_addr];
			pend_s1 <= cmd.scan_issue;
		end
	end

	// group and total counters
	logic [GF_W-1:0]   gfree_q [ibma_pkg::GROUPS];
	logic [DIR_W-1:0]  gdirs_q [ibma_pkg::GROUPS];
	logic [SLOT_W-1:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ibma_pkg::GROUPS; i++) begin
				gfree_q[i] <= '0;
				gdirs_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			if (cmd.sweep_step && word_q == '0) begin
				gfree_q[grp_idx] <= cap_c;
				gdirs_q[grp_idx] <= '0;
			end
			if (cmd.alloc_commit) begin
				gfree_q[grp_idx] <= gfree_q[grp_idx] - GF_W'(1);
				if (dir_q && gdirs_q[grp_idx] != ibma_pkg::DIRS_MAX)
					gdirs_q[grp_idx] <= gdirs_q[grp_idx] + DIR_W'(1);
				total_q <= total_q - SLOT_W'(1);
			end
			if (cmd.free_commit) begin
				if (gfree_q[grp_idx] < cap_c)
					gfree_q[grp_idx] <= gfree_q[grp_idx] + GF_W'(1);
				if (dir_q && gdirs_q[grp_idx] != '0)
					gdirs_q[grp_idx] <= gdirs_q[grp_idx] - DIR_W'(1);
				if (total_q < cnt_q)
					total_q <= total_q + SLOT_W'(1);
			end
			if (cmd.total_load) total_q <= cnt_q;
		end
	end

	// result
	logic [SLOT_W-1:0] slot_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              res_ok_q;
	logic [SLOT_W-1:0] res_total_q;

	always_ff @(posedge clk) begin
		if (cmd.start) slot_q <= '0;
		else if (cmd.alloc_commit) slot_q <= base_q + SLOT_W'({widx_s1, lz_c}) + SLOT_W'(1);
		if (cmd.out_load) begin
			res_slot_q  <= slot_q;
			res_ok_q    <= cmd.out_ok;
			res_total_q <= total_q;
		end
	end

	assign result_slot = res_slot_q;
	assign ok          = res_ok_q;
	assign free_total  = res_total_q;

	// status
	always_comb begin
		sts.total_zero = (total_q == '0);
		sts.grp_end    = (grp_q == GCNT_W'(ibma_pkg::GROUPS)) || !in_grp_c;
		sts.gfree_zero = (gfree_q[grp_idx] == '0);
		sts.word_end   = (word_q == wpg_q);
		sts.pend       = pend_s1;
		sts.word_full  = (rd_word == '1);
		sts.free_bad   = bad_q;
		sts.rem_ge_spg = (rem_q >= SLOT_W'(spg_q));
		sts.sweep_last = (grp_q == GCNT_W'(ibma_pkg::GROUPS - 1)) && sweep_wrap;
	end

	`IBMA_ASSERT_IMP(a_one_writer, clk, arst_n, 1'b1, $onehot0({cmd.sweep_step, cmd.alloc_commit, cmd.free_commit}), "bitmap written by two commands")
	`IBMA_ASSERT_IMP(a_alloc_src, clk, arst_n, cmd.alloc_commit, (pend_s1 && rd_word != '1 && gfree_q[grp_idx] != '0), "allocate without free slot")
	`IBMA_ASSERT_IMP(a_free_rmw, clk, arst_n, cmd.free_commit, $past(cmd.free_read), "free commit without read")

endmodule

@@ hw/rtl/inode_bitmap_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inode_bitmap_allocator
// Grouped first-fit slot allocator over a 128 x 32 usage bitmap, with
// per-group free and directory counters and a total free counter.
// ----------------------------------------------------------------------------
//  Channel | Dir | Payload                                  | Transaction
//  req     | in  | action, slot_number, is_directory        | valid & ready
//  rsp     | out | result_slot, ok, free_total              | valid & ready
//  cfg     | in  | index (0 group size, 1 slot count), data | valid & ready
//
//  One request at a time; the response register holds a finished result
//  while the next request is taken. Allocate visits the groups in order
//  and reads one bitmap word at a time from each until a clear bit is
//  found, a pace set by the single read port of the bitmap. Free divides
//  the slot number by repeated subtraction of the group size, then reads
//  and writes back one word. Init writes one word per cycle.
//  Reset clears counters and word valid bits at once; cfg is always ready.
// ----------------------------------------------------------------------------
module inode_bitmap_allocator (
	input  logic       clk,
	input  logic       arst_n,
	ibma_req_if.sink   req,
	ibma_rsp_if.source rsp,
	ibma_cfg_if.sink   cfg
);

	ibma_pkg::cmd_t cmd;
	ibma_pkg::sts_t sts;

	assign cfg.ready = 1'b1;

	ibma_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_action (req.action),
		.req_ready  (req.ready),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ibma_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg.valid),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.req_slot_number  (req.slot_number),
		.req_is_directory (req.is_directory),
		.cmd              (cmd),
		.sts              (sts),
		.result_slot      (rsp.result_slot),
		.ok               (rsp.ok),
		.free_total       (rsp.free_total)
	);

endmodule
